[rtl/scs_pkg.sv]
// Shared types and codes for the subsuming clause store.
package scs_pkg;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_READ   = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;

   localparam logic [2:0] STATUS_APPENDED  = 3'd0;
   localparam logic [2:0] STATUS_DISCARDED = 3'd1;
   localparam logic [2:0] STATUS_REPLACED  = 3'd2;
   localparam logic [2:0] STATUS_FULL      = 3'd3;
   localparam logic [2:0] STATUS_READ_OK   = 3'd4;
   localparam logic [2:0] STATUS_READ_OOR  = 3'd5;
   localparam logic [2:0] STATUS_CLEARED   = 3'd6;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] pos_mask;
      logic [63:0] neg_mask;
      logic        clause_is_taut;
      logic [5:0]  read_index;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [6:0]  clause_count;
      logic [6:0]  max_var;
      logic [63:0] read_pos;
      logic [63:0] read_neg;
      logic        read_taut;
   } rsp_type;

   typedef struct packed {
      logic        taut;
      logic [63:0] neg;
      logic [63:0] pos;
   } clause_type;

   typedef struct packed {
      logic old_implies_new;
      logic new_implies_old;
   } match_type;

endpackage

[rtl/scs_clause_ram.sv]
// Clause memory: one write port, one read port with registered read data.
module scs_clause_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [AW-1:0]          wr_addr,
   input  scs_pkg::clause_type    wr_data,
   input  logic [AW-1:0]          rd_addr,
   output scs_pkg::clause_type    rd_data
);

   scs_pkg::clause_type mem [DEPTH];
   scs_pkg::clause_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/scs_imply.sv]
// Subsumption compare between the new clause and a stored clause, plus top variable.
module scs_imply (
   input  scs_pkg::clause_type new_clause,
   input  scs_pkg::clause_type stored_clause,
   output scs_pkg::match_type  match,
   output logic [6:0]          top_var
);

   // true when clause a implies clause b
   function automatic logic clause_covers(input scs_pkg::clause_type a,
                                          input scs_pkg::clause_type b);
      logic res;
      if (b.taut) begin
         res = 1'b1;
      end else if (a.taut) begin
         res = 1'b0;
      end else begin
         res = ((a.pos & ~b.pos) == '0) && ((a.neg & ~b.neg) == '0);
      end
      return res;
   endfunction

   // binary search for the highest set bit, one halving per step
   function automatic logic [6:0] highest_bit(input logic [63:0] m);
      logic [63:0] x;
      logic [5:0]  v;
      x = m;
      v = '0;
      if (x[63:32] != '0) begin
         v[5] = 1'b1;
         x = x >> 32;
      end
      if (x[31:16] != '0) begin
         v[4] = 1'b1;
         x = x >> 16;
      end
      if (x[15:8] != '0) begin
         v[3] = 1'b1;
         x = x >> 8;
      end
      if (x[7:4] != '0) begin
         v[2] = 1'b1;
         x = x >> 4;
      end
      if (x[3:2] != '0) begin
         v[1] = 1'b1;
         x = x >> 2;
      end
      if (x[1]) begin
         v[0] = 1'b1;
      end
      return (m == '0) ? 7'd0 : ({1'b0, v} + 7'd1);
   endfunction

   assign match.old_implies_new = clause_covers(stored_clause, new_clause);
   assign match.new_implies_old = clause_covers(new_clause, stored_clause);
   assign top_var               = highest_bit(new_clause.pos | new_clause.neg);

endmodule

[rtl/subsuming_clause_store_core.sv]
// Subsuming clause store: control sequencer around the clause memory.
//
//  channel   ports                      handshake
//  -------   -------------------------  ---------------------------------------
//  request   start, busy, req_data      taken when start high and busy low
//  result    rsp_strobe, rsp_data       one-cycle strobe, cannot be held off
//
// Insert scans the entries in order; it answers when it appends, replaces or is dropped
// as full, or when entry i discards it: the clause memory gives one entry per cycle on
// its read port; a replacement carries straight on from the scan into compaction, so
// both walks together cover the table once. A read of a stored entry answers from the
// READ state, behind the registered read port; clear, out-of-range reads and unknown
// kinds answer from idle. Synchronous reset empties the table at once, no clearing pass.
module subsuming_clause_store_core #(
   parameter int NUM_VARS    = 64,
   parameter int TABLE_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  scs_pkg::req_type  req_data,
   output logic              rsp_strobe,
   output scs_pkg::rsp_type  rsp_data
);

   localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW   = $clog2(TABLE_DEPTH + 1);
   localparam int CMPW = (CW > 6) ? CW : 6;
   localparam logic [63:0] VarMask =
      (NUM_VARS >= 64) ? {64{1'b1}} : ((64'd1 << NUM_VARS) - 64'd1);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_SCAN    = 2'd1;
   localparam logic [1:0] ST_COMPACT = 2'd2;
   localparam logic [1:0] ST_READ    = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [6:0]          highest_ff, highest_in;
   logic [CW-1:0]       issue_ff, issue_in;
   logic                pend_ff, pend_in;
   logic [CW-1:0]       pend_idx_ff, pend_idx_in;
   logic [CW-1:0]       wr_ptr_ff, wr_ptr_in;
   scs_pkg::clause_type new_ff, new_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   scs_pkg::rsp_type    rsp_ff, rsp_in;

   logic                mem_wr_en;
   logic [AW-1:0]       mem_wr_addr;
   scs_pkg::clause_type mem_wr_data;
   logic [AW-1:0]       mem_rd_addr;
   scs_pkg::clause_type mem_rd_data;
   scs_pkg::match_type  match;
   logic [6:0]          new_top_var;

   scs_pkg::clause_type req_clause;
   logic                respond;
   logic [2:0]          rsp_status;
   logic                rsp_with_entry;

   scs_clause_ram #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   scs_imply u_imply (
      .new_clause    (new_ff),
      .stored_clause (mem_rd_data),
      .match         (match),
      .top_var       (new_top_var)
   );

   // complementary literals make a tautology, stored with empty masks
   always_comb begin
      req_clause.pos  = req_data.pos_mask & VarMask;
      req_clause.neg  = req_data.neg_mask & VarMask;
      req_clause.taut = req_data.clause_is_taut || ((req_clause.pos & req_clause.neg) != '0);
      if (req_clause.taut) begin
         req_clause.pos = '0;
         req_clause.neg = '0;
      end
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      highest_in     = highest_ff;
      issue_in       = issue_ff;
      pend_in        = 1'b0;
      pend_idx_in    = pend_idx_ff;
      wr_ptr_in      = wr_ptr_ff;
      new_in         = new_ff;
      mem_rd_addr    = AW'(issue_ff);
      mem_wr_en      = 1'b0;
      mem_wr_addr    = AW'(wr_ptr_ff);
      mem_wr_data    = new_ff;
      respond        = 1'b0;
      rsp_status     = scs_pkg::STATUS_READ_OOR;
      rsp_with_entry = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_data.kind)
                  scs_pkg::KIND_INSERT: begin
                     new_in   = req_clause;
                     issue_in = '0;
                     state_in = ST_SCAN;
                  end
                  scs_pkg::KIND_READ: begin
                     if (CMPW'(req_data.read_index) < CMPW'(count_ff)) begin
                        mem_rd_addr = AW'(CMPW'(req_data.read_index));
                        state_in    = ST_READ;
                     end else begin
                        respond = 1'b1;
                     end
                  end
                  scs_pkg::KIND_CLEAR: begin
                     count_in   = '0;
                     highest_in = '0;
                     respond    = 1'b1;
                     rsp_status = scs_pkg::STATUS_CLEARED;
                  end
                  default: begin
                     respond = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            respond        = 1'b1;
            rsp_status     = scs_pkg::STATUS_READ_OK;
            rsp_with_entry = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_SCAN: begin
            if (issue_ff < count_ff) begin
               pend_in     = 1'b1;
               pend_idx_in = issue_ff;
               issue_in    = CW'(issue_ff + 1'b1);
            end
            if (pend_ff) begin
               if (match.old_implies_new) begin
                  respond    = 1'b1;
                  rsp_status = scs_pkg::STATUS_DISCARDED;
                  state_in   = ST_IDLE;
               end else if (match.new_implies_old) begin
                  // drop this entry and close up from here; next read is already out
                  wr_ptr_in = pend_idx_ff;
                  state_in  = ST_COMPACT;
               end
            end else if (issue_ff >= count_ff) begin
               respond  = 1'b1;
               state_in = ST_IDLE;
               if (count_ff == CW'(TABLE_DEPTH)) begin
                  rsp_status = scs_pkg::STATUS_FULL;
               end else begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = AW'(count_ff);
                  count_in    = CW'(count_ff + 1'b1);
                  if (new_top_var > highest_ff) begin
                     highest_in = new_top_var;
                  end
                  rsp_status = scs_pkg::STATUS_APPENDED;
               end
            end
         end
         ST_COMPACT: begin
            if (issue_ff < count_ff) begin
               pend_in     = 1'b1;
               pend_idx_in = issue_ff;
               issue_in    = CW'(issue_ff + 1'b1);
            end
            if (pend_ff) begin
               if (!match.new_implies_old) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_data = mem_rd_data;
                  wr_ptr_in   = CW'(wr_ptr_ff + 1'b1);
               end
            end else begin
               mem_wr_en  = 1'b1;
               count_in   = CW'(wr_ptr_ff + 1'b1);
               respond    = 1'b1;
               rsp_status = scs_pkg::STATUS_REPLACED;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_strobe_in       = respond;
      rsp_in              = rsp_ff;
      if (respond) begin
         rsp_in.status       = rsp_status;
         rsp_in.clause_count = 7'(count_in);
         rsp_in.max_var      = highest_in;
         rsp_in.read_pos     = rsp_with_entry ? mem_rd_data.pos : '0;
         rsp_in.read_neg     = rsp_with_entry ? mem_rd_data.neg : '0;
         rsp_in.read_taut    = rsp_with_entry ? mem_rd_data.taut : 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         highest_ff    <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         highest_ff    <= highest_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff    <= issue_in;
      pend_idx_ff <= pend_idx_in;
      wr_ptr_ff   <= wr_ptr_in;
      new_ff      <= new_in;
      rsp_ff      <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

[rtl/scs_checker.sv]
// Port-level checks for the subsuming clause store, bound to the top level.
module scs_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input scs_pkg::req_type req_data,
   input logic             rsp_strobe,
   input scs_pkg::rsp_type rsp_data
);

   // an accepted item is either still in work or answered in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted item neither in work nor answered");

   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.kind == scs_pkg::KIND_CLEAR) |=>
         (rsp_strobe && rsp_data.status == scs_pkg::STATUS_CLEARED &&
          rsp_data.clause_count == 7'd0 && rsp_data.max_var == 7'd0))
      else $error("clear did not empty the table");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status != scs_pkg::STATUS_READ_OK) |->
         (rsp_data.read_pos == '0 && rsp_data.read_neg == '0 && !rsp_data.read_taut))
      else $error("entry fields set on a result that is not a read");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.status == scs_pkg::STATUS_APPENDED ||
                      rsp_data.status == scs_pkg::STATUS_REPLACED)) |->
         (rsp_data.clause_count != 7'd0))
      else $error("store reported with an empty table");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while still busy");

endmodule

bind subsuming_clause_store_core scs_checker u_scs_checker (.*);
